// ===== design/bcd_pkg.sv =====
package bcd_pkg;

  // fixed geometry of the detector
  localparam int CHORDS      = 4;
  localparam int SLOTS       = 4;
  localparam int BUTTON_BITS = 8;
  localparam int WINDOW_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int SETUP_W     = SLOTS * BUTTON_BITS + SLOTS + WINDOW_BITS;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = $clog2(CHORDS) + 3;

  // event kinds
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // chord phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PROCESS = 3'd1;
  localparam logic [2:0] PH_BEGIN   = 3'd2;
  localparam logic [2:0] PH_ACTIVE  = 3'd3;
  localparam logic [2:0] PH_FINISH  = 3'd4;

  // one chord's setup register, laid out as the register bits
  typedef struct packed {
    logic [WINDOW_BITS-1:0]            window;
    logic [SLOTS-1:0]                  used;
    logic [SLOTS-1:0][BUTTON_BITS-1:0] codes;
  } setup_t;

  // one chord's running state
  typedef struct packed {
    logic [2:0]           phase;
    logic [SLOTS-1:0]     pressed;
    logic [TIME_BITS-1:0] start;
  } chord_t;

endpackage

// ===== design/bcd_regs.sv =====
module bcd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcd_pkg::DATA_W-1:0]  pwdata,
  output logic [bcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bcd_pkg::setup_t             setup [bcd_pkg::CHORDS]
);

  localparam int IDX_W = bcd_pkg::ADDR_W - 3;

  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[bcd_pkg::ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // setup register file, one 52-bit setup per chord at each 64-bit word address
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < bcd_pkg::CHORDS; c++) begin
        setup[c] <= '0;
      end
    end else if (wr_en) begin
      setup[idx] <= bcd_pkg::setup_t'(pwdata[bcd_pkg::SETUP_W-1:0]);
    end
  end

  // read back, upper bits zero
  assign prdata = {{(bcd_pkg::DATA_W - bcd_pkg::SETUP_W){1'b0}}, setup[idx]};

endmodule

// ===== design/bcd_chord.sv =====
module bcd_chord (
  input  bcd_pkg::setup_t                  setup,
  input  bcd_pkg::chord_t                  cur,
  input  logic [1:0]                       command,
  input  logic [bcd_pkg::BUTTON_BITS-1:0]  button,
  input  logic [bcd_pkg::TIME_BITS-1:0]    now_ms,
  output bcd_pkg::chord_t                  nxt
);

  logic [bcd_pkg::TIME_BITS-1:0] elapsed;

  assign elapsed = now_ms - cur.start;

  // next state of one chord for one event
  always_comb begin
    nxt = cur;
    case (command)
      bcd_pkg::CMD_PRESS: begin
        // matching slots act in slot order, each on the previous result
        for (int s = 0; s < bcd_pkg::SLOTS; s++) begin
          if (setup.used[s] && (setup.codes[s] == button)) begin
            nxt.pressed[s] = 1'b1;
            if (nxt.phase == bcd_pkg::PH_IDLE) begin
              nxt.start = now_ms;
              nxt.phase = bcd_pkg::PH_PROCESS;
            end else if ((nxt.pressed & setup.used) == setup.used) begin
              nxt.phase = bcd_pkg::PH_BEGIN;
            end
          end
        end
      end
      bcd_pkg::CMD_RELEASE: begin
        for (int s = 0; s < bcd_pkg::SLOTS; s++) begin
          if (setup.used[s] && (setup.codes[s] == button)) begin
            nxt.phase   = (nxt.phase == bcd_pkg::PH_PROCESS) ? bcd_pkg::PH_IDLE
                                                              : bcd_pkg::PH_FINISH;
            nxt.start   = '1;
            nxt.pressed = '0;
          end
        end
      end
      bcd_pkg::CMD_TICK: begin
        case (cur.phase)
          bcd_pkg::PH_BEGIN:  nxt.phase = bcd_pkg::PH_ACTIVE;
          bcd_pkg::PH_FINISH: nxt.phase = bcd_pkg::PH_IDLE;
          bcd_pkg::PH_PROCESS: begin
            // window expired, wrapping time difference
            if (elapsed >= {{(bcd_pkg::TIME_BITS - bcd_pkg::WINDOW_BITS){1'b0}},
                            setup.window}) begin
              nxt.phase   = bcd_pkg::PH_IDLE;
              nxt.pressed = '0;
            end
          end
          default: nxt.phase = cur.phase;
        endcase
      end
      default: nxt = cur;
    endcase
  end

endmodule

// ===== design/button_chord_detector.sv =====
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------
// item     | item_valid / item_stall  | command, button, now_ms
// status   | status_valid/status_stall| chord0_status .. chord3_status
// config   | apb psel/penable/pwrite  | paddr (8*i), pwdata/prdata 64 bits
//
// one event per cycle sustained while status_stall is low; a result passes
// through the input register, then the chord update into the status register
// rst is synchronous: all chords idle, no pressed bits, setup registers zero
// a stall on status holds the status register and backs up into item_stall
// only while both the input register and the status register are full
module button_chord_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          command,
  input  logic [bcd_pkg::BUTTON_BITS-1:0]     button,
  input  logic [bcd_pkg::TIME_BITS-1:0]       now_ms,
  output logic                                status_valid,
  input  logic                                status_stall,
  output logic [2:0]                          chord0_status,
  output logic [2:0]                          chord1_status,
  output logic [2:0]                          chord2_status,
  output logic [2:0]                          chord3_status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bcd_pkg::ADDR_W-1:0]          paddr,
  input  logic [bcd_pkg::DATA_W-1:0]          pwdata,
  output logic [bcd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  bcd_pkg::setup_t setup [bcd_pkg::CHORDS];
  bcd_pkg::chord_t chord [bcd_pkg::CHORDS];
  bcd_pkg::chord_t chord_next [bcd_pkg::CHORDS];

  logic                            item_full;
  logic [1:0]                      command_q;
  logic [bcd_pkg::BUTTON_BITS-1:0] button_q;
  logic [bcd_pkg::TIME_BITS-1:0]   now_q;
  logic                            advance;
  logic [2:0]                      status [bcd_pkg::CHORDS];

  bcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .setup   (setup)
  );

  // move the held event into the chords when the status register frees up
  assign advance    = item_full && (!status_valid || !status_stall);
  assign item_stall = item_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      command_q <= command;
      button_q  <= button;
      now_q     <= now_ms;
    end
  end

  // per-chord update logic
  for (genvar c = 0; c < bcd_pkg::CHORDS; c++) begin : g_chord
    bcd_chord u_chord (
      .setup   (setup[c]),
      .cur     (chord[c]),
      .command (command_q),
      .button  (button_q),
      .now_ms  (now_q),
      .nxt     (chord_next[c])
    );
  end

  // chord state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < bcd_pkg::CHORDS; c++) begin
        chord[c] <= '{phase: bcd_pkg::PH_IDLE, pressed: '0, start: '0};
      end
    end else if (advance) begin
      chord <= chord_next;
    end
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < bcd_pkg::CHORDS; c++) begin
        status[c] <= chord_next[c].phase;
      end
    end
  end

  assign chord0_status = status[0];
  assign chord1_status = status[1];
  assign chord2_status = status[2];
  assign chord3_status = status[3];

endmodule

// ===== design/bcd_checker.sv =====
module bcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       status_valid,
  input logic       status_stall,
  input logic [2:0] chord0_status,
  input logic [2:0] chord1_status,
  input logic [2:0] chord2_status,
  input logic [2:0] chord3_status
);

  // back pressure on items only when the status side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (status_valid && status_stall))
    else $error("item stall without a stalled status transaction");

  // no status transaction right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !status_valid)
    else $error("status valid after reset");

  // every reported phase is a legal code
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> ((chord0_status <= 3'd4) && (chord1_status <= 3'd4) &&
                      (chord2_status <= 3'd4) && (chord3_status <= 3'd4)))
    else $error("illegal chord phase reported");

  // a stalled status transaction stays and holds
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    (status_valid && status_stall) |=>
      (status_valid && $stable(chord0_status) && $stable(chord1_status) &&
       $stable(chord2_status) && $stable(chord3_status)))
    else $error("stalled status transaction changed");

endmodule

bind button_chord_detector bcd_checker u_bcd_checker (.*);
